// File: hdl/tcp_fingerprint_option_parser_macros.svh
// Assertion macros shared by the parser modules.
// Every user module has a clock named clk and an active-low reset named arst_n.
`ifndef TCP_FINGERPRINT_OPTION_PARSER_MACROS_SVH
`define TCP_FINGERPRINT_OPTION_PARSER_MACROS_SVH

`ifndef SYNTHESIS
`define TFP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define TFP_ASSERT_NEXT(lbl, cond, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);
`else
`define TFP_ASSERT(lbl, prop, msg)
`define TFP_ASSERT_NEXT(lbl, cond, prop, msg)
`endif

`endif

// File: hdl/tfp_pkg.sv
package tfp_pkg;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int FIFO_CW = $clog2(FIFO_DEPTH + 1);

	localparam logic ITEM_HEADER = 1'b0;
	localparam int DF_BIT = 14;

	localparam logic [7:0] KIND_EOL = 8'd0;
	localparam logic [7:0] KIND_NOP = 8'd1;
	localparam logic [7:0] KIND_MSS = 8'd2;
	localparam logic [7:0] KIND_WSCALE = 8'd3;
	localparam logic [7:0] KIND_SACKOK = 8'd4;
	localparam logic [7:0] LEN_OVERHEAD = 8'd2;

	typedef enum logic [2:0] {
		OPT_EOL,
		OPT_NOP,
		OPT_MSS,
		OPT_WSCALE,
		OPT_SACKOK,
		OPT_OTHER
	} opt_class_t;

	// One classified request as it waits in the queue.
	typedef struct packed {
		logic is_hdr;
		logic last;
		logic [15:0] window;
		logic [7:0] ttl;
		logic df;
		logic [7:0] opt_byte;
		opt_class_t cls;
		logic [7:0] len_m2;
	} entry_t;

endpackage

// File: hdl/tfp_ifs.sv
interface tfp_in_if;
	logic valid;
	logic ready;
	logic kind;
	logic [15:0] window;
	logic [7:0] ttl;
	logic [15:0] flags_fragment;
	logic [7:0] option_byte;
	logic last;

	modport source (output valid, kind, window, ttl, flags_fragment, option_byte, last,
		input ready);
	modport sink (input valid, kind, window, ttl, flags_fragment, option_byte, last,
		output ready);
endinterface

interface tfp_out_if;
	logic valid;
	logic ready;
	logic [15:0] window_out;
	logic [7:0] ttl_out;
	logic [15:0] mss;
	logic dont_fragment;
	logic wscale_seen;
	logic [7:0] wscale;
	logic sack_ok;
	logic nop_seen;

	modport source (output valid, window_out, ttl_out, mss, dont_fragment, wscale_seen,
		wscale, sack_ok, nop_seen, input ready);
	modport sink (input valid, window_out, ttl_out, mss, dont_fragment, wscale_seen,
		wscale, sack_ok, nop_seen, output ready);
endinterface

// File: hdl/tfp_front.sv
module tfp_front
	import tfp_pkg::*;
(
	tfp_in_if.sink in_ch,
	input logic full,
	output logic push,
	output entry_t entry
);

	opt_class_t cls;

	always_comb begin
		case (in_ch.option_byte)
			KIND_EOL: cls = OPT_EOL;
			KIND_NOP: cls = OPT_NOP;
			KIND_MSS: cls = OPT_MSS;
			KIND_WSCALE: cls = OPT_WSCALE;
			KIND_SACKOK: cls = OPT_SACKOK;
			default: cls = OPT_OTHER;
		endcase
	end

	assign in_ch.ready = !full;
	assign push = in_ch.valid && !full;

	always_comb begin
		entry.is_hdr = (in_ch.kind == ITEM_HEADER);
		entry.last = in_ch.last;
		entry.window = in_ch.window;
		entry.ttl = in_ch.ttl;
		entry.df = in_ch.flags_fragment[DF_BIT];
		entry.opt_byte = in_ch.option_byte;
		entry.cls = cls;
		// Bytes left to skip after the length byte, clamped at zero.
		entry.len_m2 = (in_ch.option_byte >= LEN_OVERHEAD) ?
			(in_ch.option_byte - LEN_OVERHEAD) : 8'd0;
	end

endmodule

// File: hdl/tfp_fifo.sv
`include "tcp_fingerprint_option_parser_macros.svh"

module tfp_fifo
	import tfp_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic push,
	input entry_t push_data,
	input logic pop,
	output entry_t head,
	output logic full,
	output logic empty
);

	entry_t mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_CW-1:0] cnt_q;

	localparam logic [FIFO_AW-1:0] PTR_LAST = FIFO_AW'(FIFO_DEPTH - 1);
	localparam logic [FIFO_CW-1:0] CNT_FULL = FIFO_CW'(FIFO_DEPTH);

	assign full = (cnt_q == CNT_FULL);
	assign empty = (cnt_q == '0);
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	`TFP_ASSERT(a_fifo_no_overflow, !(push && full), "push into a full queue")
	`TFP_ASSERT(a_fifo_no_underflow, !(pop && empty), "pop from an empty queue")
	`TFP_ASSERT(a_fifo_cnt_range, cnt_q <= CNT_FULL, "queue count out of range")

endmodule

// File: hdl/tfp_back.sv
`include "tcp_fingerprint_option_parser_macros.svh"

module tfp_back
	import tfp_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic empty,
	input entry_t head,
	output logic pop,
	tfp_out_if.source out_ch
);

	typedef enum logic [2:0] {
		PH_KIND,
		PH_LEN,
		PH_MSS_HI,
		PH_MSS_LO,
		PH_WS_VAL,
		PH_SKIP
	} phase_t;

	typedef struct packed {
		phase_t phase;
		opt_class_t cur;
		logic [7:0] skip;
		logic stopped;
		logic [15:0] mss;
		logic mss_done;
		logic [7:0] wscale;
		logic fl_ws;
		logic fl_sack;
		logic fl_nop;
	} parse_t;

	localparam parse_t PARSE_CLEAR = '{
		phase: PH_KIND,
		cur: OPT_EOL,
		skip: 8'd0,
		stopped: 1'b0,
		mss: 16'd0,
		mss_done: 1'b0,
		wscale: 8'd0,
		fl_ws: 1'b0,
		fl_sack: 1'b0,
		fl_nop: 1'b0
	};

	function automatic parse_t parse_kind(parse_t s, opt_class_t c);
		parse_t n;
		n = s;
		n.cur = c;
		case (c)
			OPT_EOL: n.stopped = 1'b1;
			OPT_NOP: n.fl_nop = 1'b1;
			OPT_SACKOK: begin
				n.fl_sack = 1'b1;
				n.skip = 8'd1;
				n.phase = PH_SKIP;
			end
			OPT_MSS: begin
				n.mss_done = 1'b0;
				n.mss = 16'd0;
				n.phase = PH_LEN;
			end
			default: n.phase = PH_LEN;
		endcase
		return n;
	endfunction

	function automatic parse_t parse_byte(parse_t s, entry_t e);
		parse_t n;
		logic [7:0] dec;
		n = s;
		dec = s.skip - 8'd1;
		if (!s.stopped) begin
			case (s.phase)
				PH_KIND: n = parse_kind(s, e.cls);
				PH_LEN: begin
					if (s.cur == OPT_MSS) begin
						n.phase = PH_MSS_HI;
					end else if (s.cur == OPT_WSCALE) begin
						n.skip = e.len_m2;
						n.phase = PH_WS_VAL;
					end else begin
						n.skip = e.len_m2;
						n.phase = (e.len_m2 != 8'd0) ? PH_SKIP : PH_KIND;
					end
				end
				PH_MSS_HI: begin
					n.mss = {e.opt_byte, 8'h00};
					n.phase = PH_MSS_LO;
				end
				PH_MSS_LO: begin
					n.mss = {s.mss[15:8], e.opt_byte};
					n.mss_done = 1'b1;
					n.phase = PH_KIND;
				end
				PH_WS_VAL: begin
					n.wscale = e.opt_byte;
					n.fl_ws = 1'b1;
					if (s.skip == 8'd0) begin
						// A short length leaves nothing to skip, so the shift byte
						// is also taken as the next option kind.
						n.phase = PH_KIND;
						n = parse_kind(n, e.cls);
					end else begin
						n.skip = dec;
						n.phase = (dec != 8'd0) ? PH_SKIP : PH_KIND;
					end
				end
				PH_SKIP: begin
					if (s.skip != 8'd0) begin
						n.skip = dec;
					end
					if (s.skip <= 8'd1) begin
						n.phase = PH_KIND;
					end
				end
				default: n.phase = PH_KIND;
			endcase
		end
		return n;
	endfunction

	parse_t parse_q;
	parse_t parse_nx;
	logic [15:0] window_q;
	logic [7:0] ttl_q;
	logic df_q;
	logic [15:0] window_nx;
	logic [7:0] ttl_nx;
	logic df_nx;
	logic out_valid_q;
	logic slot_free;

	logic [15:0] res_window_q;
	logic [7:0] res_ttl_q;
	logic [15:0] res_mss_q;
	logic res_df_q;
	logic res_ws_seen_q;
	logic [7:0] res_ws_q;
	logic res_sack_q;
	logic res_nop_q;

	assign slot_free = !out_valid_q || out_ch.ready;
	// A request without a result never waits on the output register.
	assign pop = !empty && (!head.last || slot_free);

	always_comb begin
		if (head.is_hdr) begin
			parse_nx = PARSE_CLEAR;
			window_nx = head.window;
			ttl_nx = head.ttl;
			df_nx = head.df;
		end else begin
			parse_nx = parse_byte(parse_q, head);
			window_nx = window_q;
			ttl_nx = ttl_q;
			df_nx = df_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parse_q <= PARSE_CLEAR;
			window_q <= 16'd0;
			ttl_q <= 8'd0;
			df_q <= 1'b0;
			out_valid_q <= 1'b0;
			res_window_q <= 16'd0;
			res_ttl_q <= 8'd0;
			res_mss_q <= 16'd0;
			res_df_q <= 1'b0;
			res_ws_seen_q <= 1'b0;
			res_ws_q <= 8'd0;
			res_sack_q <= 1'b0;
			res_nop_q <= 1'b0;
		end else begin
			if (pop && head.last) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			if (pop) begin
				window_q <= window_nx;
				ttl_q <= ttl_nx;
				df_q <= df_nx;
				if (head.last) begin
					parse_q <= PARSE_CLEAR;
					res_window_q <= window_nx;
					res_ttl_q <= ttl_nx;
					res_mss_q <= parse_nx.mss_done ? parse_nx.mss : 16'd0;
					res_df_q <= df_nx;
					res_ws_seen_q <= parse_nx.fl_ws;
					res_ws_q <= parse_nx.fl_ws ? parse_nx.wscale : 8'd0;
					res_sack_q <= parse_nx.fl_sack;
					res_nop_q <= parse_nx.fl_nop;
				end else begin
					parse_q <= parse_nx;
				end
			end
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.window_out = res_window_q;
	assign out_ch.ttl_out = res_ttl_q;
	assign out_ch.mss = res_mss_q;
	assign out_ch.dont_fragment = res_df_q;
	assign out_ch.wscale_seen = res_ws_seen_q;
	assign out_ch.wscale = res_ws_q;
	assign out_ch.sack_ok = res_sack_q;
	assign out_ch.nop_seen = res_nop_q;

	`TFP_ASSERT(a_stop_in_kind, !parse_q.stopped || parse_q.phase == PH_KIND, "stop off kind")
	`TFP_ASSERT(a_ws_clear, parse_q.fl_ws || parse_q.wscale == 8'd0, "shift byte without seen flag")
	`TFP_ASSERT_NEXT(a_emit, pop && head.last, out_valid_q, "last request gave no result")

endmodule

// File: hdl/tcp_fingerprint_option_parser.sv
// Channel   Dir  Payload
// in_ch     in   kind, window, ttl, flags_fragment, option_byte, last
// out_ch    out  window_out, ttl_out, mss, dont_fragment, wscale_seen, wscale, sack_ok, nop_seen
//
// One request is accepted per cycle while the queue is not full; the parser in the back end
// retires one queued request per cycle, but a request marked last waits while a result is unaccepted.
// A result is registered: its last request is first written to the queue, and the result
// register loads when the back end pops that request from the queue.
// Reset is asynchronous and takes effect at once; there is no clearing pass.
// A stalled output holds only requests marked last; a four-entry queue absorbs the
// stall, and in_ch.ready falls when the queue is full.
module tcp_fingerprint_option_parser
	import tfp_pkg::*;
(
	input logic clk,
	input logic arst_n,
	tfp_in_if.sink in_ch,
	tfp_out_if.source out_ch
);

	logic push;
	logic pop;
	logic full;
	logic empty;
	entry_t push_data;
	entry_t head;

	tfp_front u_front (
		.in_ch(in_ch),
		.full(full),
		.push(push),
		.entry(push_data)
	);

	tfp_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data(push_data),
		.pop(pop),
		.head(head),
		.full(full),
		.empty(empty)
	);

	tfp_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.empty(empty),
		.head(head),
		.pop(pop),
		.out_ch(out_ch)
	);

endmodule

// File: dv/tb_tcp_fingerprint_option_parser.sv
`timescale 1ns / 1ps

module tb_tcp_fingerprint_option_parser;
	import tfp_pkg::*;

	localparam bit [7:0] KIND_TIMESTAMP = 8'd8;
	localparam bit [7:0] TIMESTAMP_LEN = 8'd10;
	localparam bit [7:0] MSS_LEN = 8'd4;
	localparam bit [7:0] WSCALE_LEN = 8'd3;
	localparam bit [7:0] SACKOK_LEN = 8'd2;
	localparam int RANDOM_REQUESTS = 1250;
	localparam int HOLD_OFF_CYCLES = 200;

	typedef enum logic [2:0] {
		AWAIT_KIND,
		AWAIT_LEN,
		AWAIT_MSS_HI,
		AWAIT_MSS_LO,
		AWAIT_SHIFT,
		SKIPPING
	} parse_step_t;

	typedef struct packed {
		bit kind;
		bit [15:0] window;
		bit [7:0] ttl;
		bit [15:0] flags_fragment;
		bit [7:0] option_byte;
		bit last;
	} seg_request_t;

	typedef struct packed {
		bit [15:0] window_out;
		bit [7:0] ttl_out;
		bit [15:0] mss;
		bit dont_fragment;
		bit wscale_seen;
		bit [7:0] wscale;
		bit sack_ok;
		bit nop_seen;
	} fingerprint_t;

	class fingerprint_scoreboard;
		parse_step_t phase = AWAIT_KIND;
		bit [7:0] cur_kind;
		bit [7:0] skip_left;
		bit halted;
		bit [15:0] mss_val;
		bit mss_valid;
		bit [7:0] shift_val;
		bit shift_seen;
		bit sack_flag;
		bit nop_flag;
		bit [15:0] win_hold;
		bit [7:0] ttl_hold;
		bit df_hold;
		fingerprint_t expected_prints[$];
		int unsigned requests_taken;
		int unsigned results_checked;
		int unsigned faults;
		int unsigned mss_hits;
		int unsigned shift_hits;
		int unsigned sack_hits;

		function void clear_option_state();
			phase = AWAIT_KIND;
			cur_kind = '0;
			skip_left = '0;
			halted = 1'b0;
			mss_val = '0;
			mss_valid = 1'b0;
			shift_val = '0;
			shift_seen = 1'b0;
			sack_flag = 1'b0;
			nop_flag = 1'b0;
		endfunction

		function bit [7:0] body_len(bit [7:0] len);
			return (len >= LEN_OVERHEAD) ? len - LEN_OVERHEAD : 8'd0;
		endfunction

		function void take_kind(bit [7:0] b);
			cur_kind = b;
			case (b)
				KIND_EOL: halted = 1'b1;
				KIND_NOP: nop_flag = 1'b1;
				KIND_SACKOK: begin
					sack_flag = 1'b1;
					skip_left = 8'd1;
					phase = SKIPPING;
				end
				KIND_MSS: begin
					mss_valid = 1'b0;
					mss_val = '0;
					phase = AWAIT_LEN;
				end
				default: phase = AWAIT_LEN;
			endcase
		endfunction

		function void take_byte(bit [7:0] b);
			if (halted)
				return;
			case (phase)
				AWAIT_KIND: take_kind(b);
				AWAIT_LEN: begin
					if (cur_kind == KIND_MSS) begin
						phase = AWAIT_MSS_HI;
					end else if (cur_kind == KIND_WSCALE) begin
						skip_left = body_len(b);
						phase = AWAIT_SHIFT;
					end else begin
						skip_left = body_len(b);
						phase = (skip_left != 0) ? SKIPPING : AWAIT_KIND;
					end
				end
				AWAIT_MSS_HI: begin
					mss_val = {b, 8'h00};
					phase = AWAIT_MSS_LO;
				end
				AWAIT_MSS_LO: begin
					mss_val[7:0] = b;
					mss_valid = 1'b1;
					phase = AWAIT_KIND;
				end
				AWAIT_SHIFT: begin
					shift_val = b;
					shift_seen = 1'b1;
					// With no length left, the shift byte doubles as the next option kind.
					if (skip_left == 0) begin
						phase = AWAIT_KIND;
						take_kind(b);
					end else begin
						skip_left = skip_left - 8'd1;
						phase = (skip_left != 0) ? SKIPPING : AWAIT_KIND;
					end
				end
				SKIPPING: begin
					if (skip_left != 0)
						skip_left = skip_left - 8'd1;
					if (skip_left == 0)
						phase = AWAIT_KIND;
				end
				default: phase = AWAIT_KIND;
			endcase
		endfunction

		function void note_request(seg_request_t r);
			fingerprint_t fp;
			requests_taken++;
			if (r.kind == ITEM_HEADER) begin
				clear_option_state();
				win_hold = r.window;
				ttl_hold = r.ttl;
				df_hold = r.flags_fragment[DF_BIT];
			end else begin
				take_byte(r.option_byte);
			end
			if (r.last) begin
				fp.window_out = win_hold;
				fp.ttl_out = ttl_hold;
				fp.mss = mss_valid ? mss_val : 16'd0;
				fp.dont_fragment = df_hold;
				fp.wscale_seen = shift_seen;
				fp.wscale = shift_seen ? shift_val : 8'd0;
				fp.sack_ok = sack_flag;
				fp.nop_seen = nop_flag;
				if (fp.mss != 0)
					mss_hits++;
				if (fp.wscale_seen)
					shift_hits++;
				if (fp.sack_ok)
					sack_hits++;
				expected_prints.push_back(fp);
				clear_option_state();
			end
		endfunction

		function void check_result(fingerprint_t got);
			fingerprint_t want;
			bit bad;
			results_checked++;
			if (expected_prints.size() == 0) begin
				if (faults < 10)
					$display("%0t: unexpected result window=%h ttl=%h mss=%h", $realtime,
						got.window_out, got.ttl_out, got.mss);
				faults++;
				return;
			end
			want = expected_prints.pop_front();
			bad = 1'b0;
			if (got.window_out != want.window_out) bad = 1'b1;
			if (got.ttl_out != want.ttl_out) bad = 1'b1;
			if (got.mss != want.mss) bad = 1'b1;
			if (got.dont_fragment != want.dont_fragment) bad = 1'b1;
			if (got.wscale_seen != want.wscale_seen) bad = 1'b1;
			if (got.wscale != want.wscale) bad = 1'b1;
			if (got.sack_ok != want.sack_ok) bad = 1'b1;
			if (got.nop_seen != want.nop_seen) bad = 1'b1;
			if (bad) begin
				if (faults < 10) begin
					$display("%0t: result %0d mismatch", $realtime, results_checked);
					$display("  expected window=%h ttl=%h mss=%h df=%b ws=%b/%h sack=%b nop=%b",
						want.window_out, want.ttl_out, want.mss, want.dont_fragment,
						want.wscale_seen, want.wscale, want.sack_ok, want.nop_seen);
					$display("  actual   window=%h ttl=%h mss=%h df=%b ws=%b/%h sack=%b nop=%b",
						got.window_out, got.ttl_out, got.mss, got.dont_fragment,
						got.wscale_seen, got.wscale, got.sack_ok, got.nop_seen);
				end
				faults++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	tfp_in_if in_ch();
	tfp_out_if out_ch();

	tcp_fingerprint_option_parser uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	fingerprint_scoreboard fp_board = new();
	seg_request_t req_stream[$];

	always #4 clk = ~clk;

	function automatic void push_header(bit [15:0] w, bit [7:0] t, bit [15:0] ff, bit last);
		seg_request_t r;
		r.kind = ITEM_HEADER;
		r.window = w;
		r.ttl = t;
		r.flags_fragment = ff;
		r.option_byte = 8'($urandom);
		r.last = last;
		req_stream.push_back(r);
	endfunction

	function automatic void push_option(bit [7:0] b, bit last);
		seg_request_t r;
		r.kind = ~ITEM_HEADER;
		r.window = 16'($urandom);
		r.ttl = 8'($urandom);
		r.flags_fragment = 16'($urandom);
		r.option_byte = b;
		r.last = last;
		req_stream.push_back(r);
	endfunction

	task automatic build_directed();
		// Header that is also the last request of its segment.
		push_header(16'hFFFF, 8'hFF, 16'hFFFF, 1'b1);
		push_header(16'h0000, 8'h00, 16'hBFFF, 1'b0);
		push_option(KIND_NOP, 1'b0);
		push_option(KIND_MSS, 1'b0);
		push_option(MSS_LEN, 1'b0);
		push_option(8'hFF, 1'b0);
		push_option(8'hFF, 1'b0);
		// Window scale with a short length: the shift byte reads as SACK-permitted.
		push_option(KIND_WSCALE, 1'b0);
		push_option(SACKOK_LEN, 1'b0);
		push_option(KIND_SACKOK, 1'b0);
		push_option(SACKOK_LEN, 1'b0);
		push_option(KIND_EOL, 1'b0);
		push_option(8'hAA, 1'b1);
		// No header here, so the held header values apply.
		push_option(KIND_TIMESTAMP, 1'b0);
		push_option(8'd1, 1'b0);
		push_option(8'hFF, 1'b0);
		push_option(8'd0, 1'b0);
		push_option(KIND_MSS, 1'b0);
		push_option(MSS_LEN, 1'b0);
		push_option(8'h12, 1'b0);
		push_option(8'h34, 1'b0);
		push_option(KIND_MSS, 1'b0);
		push_option(MSS_LEN, 1'b0);
		push_option(8'h56, 1'b1);
		push_option(KIND_WSCALE, 1'b0);
		push_option(WSCALE_LEN, 1'b1);
	endtask

	task automatic build_random_segment();
		bit [7:0] body[$];
		bit with_header;
		int len;
		int cut;
		with_header = ($urandom_range(0, 9) != 0);
		if ($urandom_range(0, 11) == 0) begin
			repeat ($urandom_range(1, 4))
				push_option(8'($urandom), $urandom_range(0, 3) == 0);
			return;
		end
		repeat ($urandom_range(0, 6)) begin
			case ($urandom_range(0, 9))
				0, 9: body.push_back(KIND_NOP);
				1: begin
					body.push_back(KIND_EOL);
					repeat ($urandom_range(0, 2))
						body.push_back(8'($urandom));
				end
				2, 3: begin
					body.push_back(KIND_MSS);
					body.push_back(MSS_LEN);
					body.push_back(8'($urandom));
					body.push_back(8'($urandom));
				end
				4: begin
					len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 6) : WSCALE_LEN;
					body.push_back(KIND_WSCALE);
					body.push_back(8'(len));
					body.push_back(($urandom_range(0, 3) == 0) ?
						8'($urandom) : 8'($urandom_range(0, 14)));
					repeat ((len > 3) ? len - 3 : 0)
						body.push_back(8'($urandom));
				end
				5: begin
					body.push_back(KIND_SACKOK);
					body.push_back(SACKOK_LEN);
				end
				6: begin
					body.push_back(KIND_TIMESTAMP);
					body.push_back(TIMESTAMP_LEN);
					repeat (TIMESTAMP_LEN - 2)
						body.push_back(8'($urandom));
				end
				7: begin
					len = $urandom_range(0, 12);
					body.push_back(8'($urandom_range(5, 255)));
					body.push_back(8'(len));
					repeat ((len > 2) ? len - 2 : 0)
						body.push_back(8'($urandom));
				end
				default: body.push_back(8'($urandom));
			endcase
		end
		// Some segments end in the middle of an option.
		if (body.size() > 0 && $urandom_range(0, 6) == 0) begin
			cut = $urandom_range(1, body.size());
			while (body.size() > cut)
				void'(body.pop_back());
		end
		if (with_header)
			push_header(16'($urandom), 8'($urandom), 16'($urandom), body.size() == 0);
		else if (body.size() == 0)
			push_option(8'($urandom), 1'b1);
		foreach (body[i])
			push_option(body[i], i == body.size() - 1);
	endtask

	task automatic drive_requests();
		seg_request_t r;
		int burst;
		int gap;
		while (req_stream.size() > 0) begin
			burst = $urandom_range(1, 48);
			while (burst > 0 && req_stream.size() > 0) begin
				r = req_stream.pop_front();
				@(negedge clk);
				in_ch.valid <= 1'b1;
				in_ch.kind <= r.kind;
				in_ch.window <= r.window;
				in_ch.ttl <= r.ttl;
				in_ch.flags_fragment <= r.flags_fragment;
				in_ch.option_byte <= r.option_byte;
				in_ch.last <= r.last;
				do
					@(posedge clk);
				while (!in_ch.ready);
				fp_board.note_request(r);
				burst--;
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				@(negedge clk);
				in_ch.valid <= 1'b0;
				repeat (gap - 1)
					@(negedge clk);
			end
		end
		@(negedge clk);
		in_ch.valid <= 1'b0;
	endtask

	// Result side: the stall pattern switches among four modes, and once the output is
	// held off long enough for the request queue to fill and block new requests.
	initial begin
		int mode;
		int mode_left;
		int tick;
		bit held_off;
		out_ch.ready = 1'b0;
		mode = 0;
		mode_left = 0;
		tick = 0;
		held_off = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (!held_off && fp_board.requests_taken >= 400) begin
				held_off = 1'b1;
				out_ch.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES)
					@(negedge clk);
			end else begin
				if (mode_left == 0) begin
					mode = $urandom_range(0, 3);
					mode_left = $urandom_range(20, 120);
				end
				mode_left--;
				tick++;
				case (mode)
					0: out_ch.ready <= 1'b1;
					1: out_ch.ready <= $urandom_range(0, 1);
					2: out_ch.ready <= (tick % 4 == 0);
					default: out_ch.ready <= ($urandom_range(0, 7) == 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin : result_monitor
		fingerprint_t got;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got.window_out = out_ch.window_out;
			got.ttl_out = out_ch.ttl_out;
			got.mss = out_ch.mss;
			got.dont_fragment = out_ch.dont_fragment;
			got.wscale_seen = out_ch.wscale_seen;
			got.wscale = out_ch.wscale;
			got.sack_ok = out_ch.sack_ok;
			got.nop_seen = out_ch.nop_seen;
			fp_board.check_result(got);
		end
	end

	initial begin
		#3_200_000;
		$display("Timed out with %0d results outstanding", fp_board.expected_prints.size());
		$display("Verification failed");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.kind = 1'b0;
		in_ch.window = '0;
		in_ch.ttl = '0;
		in_ch.flags_fragment = '0;
		in_ch.option_byte = '0;
		in_ch.last = 1'b0;
		build_directed();
		while (req_stream.size() < RANDOM_REQUESTS + 26)
			build_random_segment();
		repeat (8)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		drive_requests();
		while (fp_board.expected_prints.size() != 0)
			@(posedge clk);
		repeat (10)
			@(posedge clk);
		$display("Covered %0d requests and %0d segment results with %0d mismatches.",
			fp_board.requests_taken, fp_board.results_checked, fp_board.faults);
		$display("Results carried MSS %0d times, window scale %0d times, SACK %0d times.",
			fp_board.mss_hits, fp_board.shift_hits, fp_board.sack_hits);
		if (fp_board.faults == 0 && fp_board.expected_prints.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
